FILE: src/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on the rising clock, disabled in reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assert that a condition is followed by another in the next cycle, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);

`endif

FILE: src/fvl_pkg.sv
// package for the finite volume laplacian scatter engine
package fvl_pkg;
    localparam int CELLS   = 1024;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int QUO_W   = ACC_W + 16;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_COND  = 2'd1,
        KIND_FLUX  = 2'd2,
        KIND_FINAL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_AREA = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD,
        S_MUL,
        S_FLUX,
        S_LEFT,
        S_RIGHT,
        S_DIV,
        S_OUT
    } fsm_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // saturate a 50-bit sum to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] mx;
        logic signed [ACC_W+1:0] mn;
        mn = {{2{1'b1}}, ACC_MIN};
        mx = {2'b00, ACC_MAX};
        if (v > mx) begin
            sat_acc = ACC_MAX;
        end else if (v < mn) begin
            sat_acc = ACC_MIN;
        end else begin
            sat_acc = v[ACC_W-1:0];
        end
    endfunction
endpackage

FILE: src/fvl_ram.sv
// generic single port ram with registered read
module fvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, and registered read that returns the old data on a write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: src/finite_volume_laplacian_scatter.sv
// finite volume laplacian scatter engine, top level
// a load is written from idle; flux and conductance edges update the accumulators
// finalize: result set by a shift-subtract divider giving one of 64 quotient bits per cycle,
// skipped for a non-positive area
// after reset a clearing pass zeroes the accumulator ram, no transfer taken
// a result waits in an output register; only the next finalize stalls behind it
`include "assert_macros.svh"
module finite_volume_laplacian_scatter
    import fvl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [CELL_W-1:0]        s_first_cell,
    input  logic [CELL_W-1:0]        s_second_cell,
    input  logic signed [VAL_W-1:0]  s_quantity,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CELL_W-1:0]        m_result_cell,
    output logic signed [VAL_W-1:0]  m_result_value,
    output logic [1:0]               m_status
);
    fsm_t state_reg, state_next;
    logic [1:0]              kind_reg, kind_next;
    logic [CELL_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic signed [VAL_W-1:0] q_reg, q_next;
    logic [CELL_W:0]         clr_reg, clr_next;
    logic signed [VAL_W-1:0] va_reg, va_next;
    logic signed [63:0]      prod_reg, prod_next;
    logic signed [ACC_W-1:0] flux_reg, flux_next;
    logic                    neg_reg, neg_next;
    logic [QUO_W-1:0]        num_reg, num_next;
    logic [VAL_W:0]          rem_reg, rem_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic                    ov_reg, ov_next;
    logic                    mv_reg, mv_next;
    logic [CELL_W-1:0]       mc_reg, mc_next;
    logic signed [VAL_W-1:0] mval_reg, mval_next;
    logic [1:0]              mst_reg, mst_next;

    logic                    v_we, a_we;
    logic [CELL_W-1:0]       v_addr, a_addr;
    logic [VAL_W-1:0]        v_wdata, v_rdata;
    logic [ACC_W-1:0]        a_wdata, a_rdata;

    fvl_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_val (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
    fvl_ram #(.WIDTH(ACC_W), .DEPTH(CELLS)) u_acc (
        .aclk(aclk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata));

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        kind_reg <= kind_next; a_reg <= a_next; b_reg <= b_next; q_reg <= q_next;
        va_reg <= va_next; prod_reg <= prod_next; flux_reg <= flux_next;
        neg_reg <= neg_next; num_reg <= num_next; rem_reg <= rem_next;
        cnt_reg <= cnt_next; ov_reg <= ov_next;
        mc_reg <= mc_next; mval_reg <= mval_next; mst_reg <= mst_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = mv_reg;
    assign m_result_cell  = mc_reg;
    assign m_result_value = mval_reg;
    assign m_status       = mst_reg;

    // sequencer
    always_comb begin
        logic signed [32:0]      diff;
        logic [ACC_W-1:0]        mag;
        logic [VAL_W+1:0]        trial;
        logic [VAL_W:0]          rsh;
        logic [QUO_W-1:0]        quo;
        state_next = state_reg;
        kind_next = kind_reg; a_next = a_reg; b_next = b_reg; q_next = q_reg;
        clr_next = clr_reg; va_next = va_reg; prod_next = prod_reg;
        flux_next = flux_reg; neg_next = neg_reg; num_next = num_reg;
        rem_next = rem_reg; cnt_next = cnt_reg; ov_next = ov_reg;
        mv_next = mv_reg; mc_next = mc_reg; mval_next = mval_reg; mst_next = mst_reg;
        v_we = 1'b0; a_we = 1'b0;
        v_addr = a_reg; a_addr = a_reg;
        v_wdata = q_reg; a_wdata = '0;
        diff = '0; mag = '0; trial = '0; rsh = '0; quo = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                a_we = 1'b1;
                a_addr = clr_reg[CELL_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (CELL_W+1)'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    kind_next = s_kind; a_next = s_first_cell;
                    b_next = s_second_cell; q_next = s_quantity;
                    v_addr = s_first_cell; a_addr = s_first_cell;
                    case (kind_t'(s_kind))
                        KIND_LOAD: begin
                            v_we = 1'b1;
                            v_wdata = s_quantity;
                        end
                        KIND_COND:  state_next = S_RD;
                        KIND_FLUX: begin
                            flux_next = ACC_W'(s_quantity);
                            state_next = (s_first_cell == s_second_cell) ? S_IDLE : S_LEFT;
                        end
                        KIND_FINAL: state_next = S_DIV;
                        default: state_next = S_IDLE;
                    endcase
                    cnt_next = '0;
                end
            end
            S_RD: begin
                // left value arrives, fetch right value
                va_next = v_rdata;
                v_addr = b_reg;
                state_next = S_MUL;
            end
            S_MUL: begin
                diff = 33'(signed'(v_rdata)) - 33'(va_reg);
                prod_next = 64'(diff) * 64'(q_reg);
                state_next = S_FLUX;
            end
            S_FLUX: begin
                // arithmetic shift is floor division by 2^16
                if ((prod_reg >>> 16) > 64'(ACC_MAX)) begin
                    flux_next = ACC_MAX;
                end else if ((prod_reg >>> 16) < 64'(ACC_MIN)) begin
                    flux_next = ACC_MIN;
                end else begin
                    flux_next = prod_reg[63:16];
                end
                a_addr = a_reg;
                state_next = (a_reg == b_reg) ? S_IDLE : S_LEFT;
            end
            S_LEFT: begin
                // left accumulator read was issued last cycle
                a_addr = a_reg;
                if (kind_reg == KIND_FLUX && cnt_reg == 0) begin
                    cnt_next = 7'd1;
                end else begin
                    a_we = 1'b1;
                    a_wdata = sat_acc(50'(signed'(a_rdata)) - 50'(flux_reg));
                    a_addr = a_reg;
                    state_next = S_RIGHT;
                    cnt_next = '0;
                end
            end
            S_RIGHT: begin
                a_addr = b_reg;
                if (cnt_reg == 0) begin
                    cnt_next = 7'd1;
                end else begin
                    a_we = 1'b1;
                    a_wdata = sat_acc(50'(signed'(a_rdata)) + 50'(flux_reg));
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                a_addr = a_reg;
                if (cnt_reg == 0) begin
                    cnt_next = 7'd1;
                end else if (cnt_reg == 1) begin
                    // latch magnitude, clear accumulator
                    a_we = 1'b1;
                    a_wdata = '0;
                    mag = a_rdata[ACC_W-1] ? -a_rdata : a_rdata;
                    neg_next = !a_rdata[ACC_W-1] && (a_rdata != '0);
                    num_next = {mag, 16'd0};
                    rem_next = '0;
                    cnt_next = 7'd2;
                    if (q_reg <= 0) begin
                        state_next = S_OUT;
                    end
                end else begin
                    // one quotient bit a cycle
                    trial = {rem_reg, num_reg[QUO_W-1]} - {2'b00, q_reg};
                    rsh = {rem_reg[VAL_W-1:0], num_reg[QUO_W-1]};
                    if (!trial[VAL_W+1]) begin
                        rem_next = trial[VAL_W:0];
                        num_next = {num_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_next = rsh;
                        num_next = {num_reg[QUO_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 7'(QUO_W + 1)) begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // wait here while the previous result is still held
                if (!mv_reg || m_ready) begin
                    quo = num_reg;
                    mc_next = a_reg;
                    mv_next = 1'b1;
                    if (q_reg <= 0) begin
                        mst_next = ST_AREA; mval_next = '0;
                    end else if (neg_reg) begin
                        if (quo > 64'h8000_0000) begin
                            mst_next = ST_SAT; mval_next = 32'sh8000_0000;
                        end else begin
                            mst_next = ST_OK; mval_next = -quo[VAL_W-1:0];
                        end
                    end else if (quo > 64'h7FFF_FFFF) begin
                        mst_next = ST_SAT; mval_next = 32'sh7FFF_FFFF;
                    end else begin
                        mst_next = ST_OK; mval_next = quo[VAL_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // assertions
    `ASSERT_CLK(a_no_take_busy, aclk, aresetn, s_ready |-> (state_reg == S_IDLE), "ready while busy")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_result_value), "result changed")
    `ASSERT_CLK(a_stat_area, aclk, aresetn, (m_valid && m_status == ST_AREA) |-> (m_result_value == 0), "area err nonzero")
endmodule
